/* src/tbsd_pkg.sv */
// Shared types and constants of the text byte stream decoder.
`default_nettype none
package tbsd_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int TAB_IDX_W   = $clog2(TABLE_DEPTH);

  localparam logic [2:0] MODE_CP8   = 3'd0;
  localparam logic [2:0] MODE_UTF8  = 3'd1;
  localparam logic [2:0] MODE_U16LE = 3'd2;
  localparam logic [2:0] MODE_U16BE = 3'd3;
  localparam logic [2:0] MODE_U32LE = 3'd4;
  localparam logic [2:0] MODE_U32BE = 3'd5;
  localparam logic [2:0] MODE_RESET = MODE_UTF8;

  localparam logic OP_DECODE   = 1'b0;
  localparam logic OP_TABLE_WR = 1'b1;

  localparam logic [23:0] QMARK = 24'h00003F;

  // UTF-8 byte class, worked out in the front.
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } cls_e;

  typedef struct packed {
    logic                 op;
    logic [7:0]           data_byte;
    logic                 last_byte;
    logic [TAB_IDX_W-1:0] table_index;
    logic [15:0]          table_value;
    cls_e                 cls;
  } item_t;

endpackage
`default_nettype wire

/* src/tbsd_front.sv */
// Front end: unpacks an incoming transaction and classifies its byte.
`default_nettype none
module tbsd_front
  import tbsd_pkg::*;
(
  input  wire logic                 op_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 last_byte_i,
  input  wire logic [TAB_IDX_W-1:0] table_index_i,
  input  wire logic [15:0]          table_value_i,
  output item_t                     item_o
);

  cls_e cls;

  always_comb begin
    if (!data_byte_i[7]) begin
      cls = CLS_ASCII;
    end else if (data_byte_i[6] == 1'b0) begin
      cls = CLS_CONT;
    end else if (data_byte_i >= 8'hC2 && data_byte_i <= 8'hDF) begin
      cls = CLS_LEAD2;
    end else if (data_byte_i >= 8'hE0 && data_byte_i <= 8'hEF) begin
      cls = CLS_LEAD3;
    end else if (data_byte_i >= 8'hF0 && data_byte_i <= 8'hF4) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_INVALID;
    end
  end

  always_comb begin
    item_o.op          = op_i;
    item_o.data_byte   = data_byte_i;
    item_o.last_byte   = last_byte_i;
    item_o.table_index = table_index_i;
    item_o.table_value = table_value_i;
    item_o.cls         = cls;
  end

endmodule
`default_nettype wire

/* src/tbsd_queue.sv */
// Small FIFO of classified items between the front and the back end.
`default_nettype none
module tbsd_queue
  import tbsd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       ready_o,
  output logic       valid_o,
  input  wire logic  pop_i,
  output item_t      item_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

/* src/tbsd_back.sv */
// Back end: code page table, unit assembly, UTF-8 decoding and output register.
`default_nettype none
module tbsd_back
  import tbsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [23:0]      m_code_point_o,
  output logic             m_replaced_o
);

  logic [15:0] table_mem [TABLE_DEPTH];
  logic [15:0] tab_rd_q;

  logic [2:0]  mode_q;
  logic [23:0] pw_q, pw_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  rem_q, rem_d;

  logic        out_valid_q;
  logic [23:0] out_cp_q;
  logic        out_bad_q;
  logic        out_tab_q;

  logic        res_valid;
  logic [23:0] res_cp;
  logic        res_bad;
  logic        use_tab;
  logic        slot_free;
  logic [7:0]  b;
  logic [1:0]  len;
  logic [1:0]  rem_dec;
  logic [20:0] val;

  assign b         = q_item_i.data_byte;
  assign len       = pw_q[23:22];
  assign rem_dec   = rem_q - 2'd1;
  assign val       = {pw_q[14:0], b[5:0]};
  assign slot_free = !out_valid_q || m_ready_i;
  assign q_pop_o   = q_valid_i && slot_free;

  always_comb begin
    pw_d      = pw_q;
    phase_d   = phase_q;
    rem_d     = rem_q;
    res_valid = 1'b0;
    res_cp    = '0;
    res_bad   = 1'b0;
    use_tab   = 1'b0;
    if (q_item_i.op == OP_DECODE) begin
      case (mode_q)
        MODE_CP8: begin
          res_valid = 1'b1;
          use_tab   = b[7];
          res_cp    = {16'd0, b};
        end
        MODE_UTF8: begin
          if (rem_q == 2'd0) begin
            case (q_item_i.cls)
              CLS_ASCII: begin
                res_valid = 1'b1;
                res_cp    = {16'd0, b};
              end
              CLS_LEAD2: begin
                pw_d  = {2'd1, 1'b0, 16'd0, b[4:0]};
                rem_d = 2'd1;
              end
              CLS_LEAD3: begin
                pw_d  = {2'd2, 1'b0, 17'd0, b[3:0]};
                rem_d = 2'd2;
              end
              CLS_LEAD4: begin
                pw_d  = {2'd3, 1'b0, 18'd0, b[2:0]};
                rem_d = 2'd3;
              end
              default: begin
                res_valid = 1'b1;
                res_cp    = QMARK;
                res_bad   = 1'b1;
              end
            endcase
          end else if (q_item_i.cls != CLS_CONT) begin
            // A broken sequence and the byte that broke it give one '?'.
            pw_d      = '0;
            rem_d     = 2'd0;
            res_valid = 1'b1;
            res_cp    = QMARK;
            res_bad   = 1'b1;
          end else if (rem_dec != 2'd0) begin
            pw_d  = {len, 1'b0, val};
            rem_d = rem_dec;
          end else begin
            pw_d      = '0;
            rem_d     = 2'd0;
            res_valid = 1'b1;
            if ((len == 2'd2 && (val < 21'h000800 ||
                                 (val >= 21'h00D800 && val <= 21'h00DFFF))) ||
                (len == 2'd3 && (val < 21'h010000 || val > 21'h10FFFF))) begin
              res_cp  = QMARK;
              res_bad = 1'b1;
            end else begin
              res_cp = {3'd0, val};
            end
          end
        end
        MODE_U16LE, MODE_U16BE: begin
          if (phase_q == 2'd0) begin
            pw_d    = {16'd0, b};
            phase_d = 2'd1;
          end else begin
            res_valid = 1'b1;
            res_cp    = (mode_q == MODE_U16LE) ? {8'd0, b, pw_q[7:0]}
                                               : {8'd0, pw_q[7:0], b};
            pw_d      = '0;
            phase_d   = 2'd0;
          end
        end
        MODE_U32LE: begin
          case (phase_q)
            2'd0: pw_d = pw_q | {16'd0, b};
            2'd1: pw_d = pw_q | {8'd0, b, 8'd0};
            2'd2: pw_d = pw_q | {b, 16'd0};
            default: begin
              // The top byte of the unit is dropped.
              res_valid = 1'b1;
              res_cp    = pw_q;
              pw_d      = '0;
            end
          endcase
          phase_d = phase_q + 2'd1;
        end
        MODE_U32BE: begin
          if (phase_q == 2'd0) begin
            pw_d    = '0;
            phase_d = 2'd1;
          end else if (phase_q == 2'd3) begin
            res_valid = 1'b1;
            res_cp    = {pw_q[15:0], b};
            pw_d      = '0;
            phase_d   = 2'd0;
          end else begin
            pw_d    = {pw_q[15:0], b};
            phase_d = phase_q + 2'd1;
          end
        end
        default: begin
          pw_d    = '0;
          phase_d = 2'd0;
          rem_d   = 2'd0;
        end
      endcase
      if (q_item_i.last_byte) begin
        pw_d    = '0;
        phase_d = 2'd0;
        rem_d   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RESET;
      pw_q        <= '0;
      phase_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q  <= cfg_wdata_i;
        pw_q    <= '0;
        phase_q <= '0;
        rem_q   <= '0;
      end else if (q_pop_o) begin
        pw_q    <= pw_d;
        phase_q <= phase_d;
        rem_q   <= rem_d;
      end
      if (slot_free) begin
        out_valid_q <= q_pop_o && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_cp_q  <= res_cp;
      out_bad_q <= res_bad;
      out_tab_q <= use_tab;
    end
  end

  // The table read data is registered and only moves when an item is taken.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.op == OP_TABLE_WR) begin
      table_mem[q_item_i.table_index] <= q_item_i.table_value;
    end
    if (q_pop_o && use_tab) begin
      tab_rd_q <= table_mem[b[TAB_IDX_W-1:0]];
    end
  end

  assign m_valid_o      = out_valid_q;
  assign m_code_point_o = out_tab_q ? {8'd0, tab_rd_q} : out_cp_q;
  assign m_replaced_o   = out_bad_q;

`ifndef SYNTHESIS
  a_rem_only_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 2'd0 |-> mode_q == MODE_UTF8)
    else $error("UTF-8 continuation count set outside UTF-8 mode");

  a_rem_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 2'd0 |-> pw_q[23:22] >= rem_q)
    else $error("UTF-8 remaining count exceeds sequence length");

  a_phase_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd0 |-> (mode_q == MODE_U16LE || mode_q == MODE_U16BE ||
                         mode_q == MODE_U32LE || mode_q == MODE_U32BE))
    else $error("byte phase set outside a multi-byte unit mode");

  a_u16_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_U16LE || mode_q == MODE_U16BE) |-> phase_q <= 2'd1)
    else $error("UTF-16 byte phase out of range");

  a_tab_wr_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && q_item_i.op == OP_TABLE_WR |=> !out_valid_q)
    else $error("table write produced a result");
`endif

endmodule
`default_nettype wire

/* src/text_byte_stream_decoder.sv */
// Top level of the text byte stream decoder.
`default_nettype none
// Decodes a stream of text bytes into Unicode code points in one of six modes
// selected by cfg_wdata_i: 8-bit code page, UTF-8, UTF-16 LE/BE, UTF-32 LE/BE.
// tuser on the input selects a byte to decode (0) or a code page table write
// (1); tlast ends a stream and drops any incomplete unit. The block takes one
// transaction per cycle while its queue is not full; a queue of QUEUE_DEPTH
// items sits between the input and the decode stage, which updates the
// assembly state and reads the 128-entry code page RAM. Sustained throughput
// is one byte per cycle unless the output holds off results. A result is
// registered as its byte leaves the queue and held until it is accepted.
// Table entries must be written before they are read. Write the mode only
// while the block is idle; a write clears any partial unit.
module text_byte_stream_decoder
  import tbsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] data_byte, [14:8] table_index, [30:15] table_value, [31] zero
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // [0] op
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] code_point
  output logic [23:0]      m_axis_tdata,
  // [0] replaced
  output logic             m_axis_tuser
);

  item_t front_item;
  item_t head_item;
  logic  head_valid;
  logic  head_pop;

  tbsd_front u_front (
    .op_i          (s_axis_tuser),
    .data_byte_i   (s_axis_tdata[7:0]),
    .last_byte_i   (s_axis_tlast),
    .table_index_i (s_axis_tdata[14:8]),
    .table_value_i (s_axis_tdata[30:15]),
    .item_o        (front_item)
  );

  tbsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .item_i  (front_item),
    .ready_o (s_axis_tready),
    .valid_o (head_valid),
    .pop_i   (head_pop),
    .item_o  (head_item)
  );

  tbsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (head_valid),
    .q_item_i       (head_item),
    .q_pop_o        (head_pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_code_point_o (m_axis_tdata),
    .m_replaced_o   (m_axis_tuser)
  );

endmodule
`default_nettype wire

/* bench/decode_checker.sv */
// Checker for the text byte stream decoder: predicts code points and compares them.
`timescale 1ns / 1ps
module decode_checker
  import tbsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  // [7:0] data_byte, [14:8] table_index, [30:15] table_value, [31] zero
  input  logic [31:0] in_data_i,
  input  logic        in_last_i,
  input  logic        in_op_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  input  logic        out_replaced_i,
  output int          mismatches_o,
  output int          pending_o
);

  typedef struct packed {
    logic [23:0] code_point;
    logic        replaced;
  } char_t;

  char_t       expected_chars[$];
  logic [2:0]  mode;
  logic [23:0] unit_acc;
  logic [1:0]  unit_pos;
  logic [1:0]  cont_left;
  logic [15:0] cp_table [TABLE_DEPTH];
  int          mismatch_count;

  task automatic clear_unit();
    unit_acc  = '0;
    unit_pos  = '0;
    cont_left = '0;
  endtask

  task automatic note(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  // Works out the code point, if any, that one data byte completes.
  task automatic decode_byte(input logic [7:0] b, input logic lst);
    bit          hit;
    char_t       c;
    logic [20:0] v;
    logic [1:0]  len;
    hit = 1'b0;
    c   = '0;
    case (mode)
      MODE_CP8: begin
        hit = 1'b1;
        c.code_point = b[7] ? {8'h00, cp_table[b[6:0]]} : {16'h0000, b};
      end
      MODE_UTF8: begin
        if (cont_left == 2'd0) begin
          if (b < 8'h80) begin
            hit = 1'b1;
            c.code_point = {16'h0000, b};
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            unit_acc  = {2'd1, 17'd0, b[4:0]};
            cont_left = 2'd1;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            unit_acc  = {2'd2, 18'd0, b[3:0]};
            cont_left = 2'd2;
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            unit_acc  = {2'd3, 19'd0, b[2:0]};
            cont_left = 2'd3;
          end else begin
            hit = 1'b1;
            c   = {QMARK, 1'b1};
          end
        end else if (b[7:6] != 2'b10) begin
          // The broken sequence and the byte that broke it become one '?'.
          clear_unit();
          hit = 1'b1;
          c   = {QMARK, 1'b1};
        end else begin
          len       = unit_acc[23:22];
          v         = {unit_acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          unit_acc  = {len, 1'b0, v};
          if (cont_left == 2'd0) begin
            clear_unit();
            hit = 1'b1;
            if ((len == 2'd2 && (v < 21'h800 || (v >= 21'hD800 && v <= 21'hDFFF))) ||
                (len == 2'd3 && (v < 21'h10000 || v > 21'h10FFFF)))
              c = {QMARK, 1'b1};
            else
              c = {3'b000, v, 1'b0};
          end
        end
      end
      MODE_U16LE, MODE_U16BE: begin
        if (unit_pos == 2'd0) begin
          unit_acc = {16'h0000, b};
          unit_pos = 2'd1;
        end else begin
          c.code_point = (mode == MODE_U16LE) ? {8'h00, b, unit_acc[7:0]}
                                              : {8'h00, unit_acc[7:0], b};
          clear_unit();
          hit = 1'b1;
        end
      end
      MODE_U32LE: begin
        // The fourth byte is the top one and is dropped.
        if (unit_pos < 2'd3) begin
          unit_acc = unit_acc | ({16'h0000, b} << (8 * unit_pos));
          unit_pos = unit_pos + 2'd1;
        end else begin
          c.code_point = unit_acc;
          clear_unit();
          hit = 1'b1;
        end
      end
      MODE_U32BE: begin
        if (unit_pos == 2'd0) begin
          unit_acc = '0;
          unit_pos = 2'd1;
        end else begin
          unit_acc = {unit_acc[15:0], b};
          if (unit_pos == 2'd3) begin
            c.code_point = unit_acc;
            clear_unit();
            hit = 1'b1;
          end else begin
            unit_pos = unit_pos + 2'd1;
          end
        end
      end
      default: clear_unit();
    endcase
    if (lst) clear_unit();
    if (hit) expected_chars.insert(expected_chars.size(), c);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      mode = MODE_RESET;
      clear_unit();
      mismatch_count = 0;
    end else begin
      // Results leave only after their byte has been taken, so retire before predicting.
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          note($sformatf("unexpected code point %h replaced %b", out_data_i, out_replaced_i));
        end else begin
          want = expected_chars.pop_front();
          if (out_data_i !== want.code_point)
            note($sformatf("code_point expected %h, got %h", want.code_point, out_data_i));
          if (out_replaced_i !== want.replaced)
            note($sformatf("replaced expected %b, got %b (code point %h)",
                           want.replaced, out_replaced_i, want.code_point));
        end
      end
      if (cfg_we_i) begin
        mode = cfg_wdata_i;
        clear_unit();
      end
      if (in_valid_i && in_ready_i) begin
        if (in_op_i == OP_TABLE_WR)
          cp_table[in_data_i[14:8]] = in_data_i[30:15];
        else
          decode_byte(in_data_i[7:0], in_last_i);
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= expected_chars.size();
  end

endmodule

/* bench/tb_text_byte_stream_decoder.sv */
// Testbench top for the text byte stream decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_text_byte_stream_decoder;
  import tbsd_pkg::*;

  localparam int RAND_ITEMS    = 1300;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = MODE_RESET;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = OP_DECODE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  int mismatches;
  int pending;
  int sent_count = 0;
  bit calm_sender = 1'b0;
  bit written [TABLE_DEPTH];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_byte_stream_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  decode_checker u_decode_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_i     (s_axis_tready),
    .in_data_i      (s_axis_tdata),
    .in_last_i      (s_axis_tlast),
    .in_op_i        (s_axis_tuser),
    .out_valid_i    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_i     (m_axis_tdata),
    .out_replaced_i (m_axis_tuser),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int random_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [7:0] any_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic put(input logic op, input logic [7:0] b, input logic lst,
                     input logic [6:0] idx, input logic [15:0] val);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= lst;
    s_axis_tdata  <= {1'b0, val, idx, b};
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
    gap = calm_sender ? 0 : random_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    put(OP_DECODE, b, lst, 7'($urandom), 16'($urandom));
  endtask

  task automatic load_entry(input logic [6:0] idx, input logic [15:0] val);
    put(OP_TABLE_WR, 8'($urandom), 1'($urandom), idx, val);
    written[idx] = 1'b1;
  endtask

  // Waits until every predicted code point has come out and the pipe is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sends the first keep bytes of the len-byte UTF-8 form of cp.
  task automatic utf8_seq(input logic [20:0] cp, input int len, input int keep,
                          input logic end_mark);
    logic [7:0] seq [4];
    case (len)
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(seq[i], end_mark && (i == keep - 1));
  endtask

  task automatic utf8_item();
    int          kind;
    int          len;
    logic [20:0] cp;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    case (len)
      2:       cp = 21'($urandom_range(21'h80, 21'h7FF));
      3:       cp = 21'($urandom_range(21'h800, 21'hFFFF));
      default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
    endcase
    if (len == 3 && cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp + 21'h2000;
    if (kind < 30) begin
      send_byte(8'($urandom_range(0, 8'h7F)), 1'b0);
    end else if (kind < 70) begin
      utf8_seq(cp, len, len, $urandom_range(0, 15) == 0);
    end else if (kind < 76) begin
      // Overlong forms, including the C0/C1 leads of two-byte ones.
      len = $urandom_range(2, 4);
      cp  = (len == 2) ? 21'($urandom_range(0, 8'h7F))
          : (len == 3) ? 21'($urandom_range(0, 21'h7FF))
                       : 21'($urandom_range(0, 21'hFFFF));
      utf8_seq(cp, len, len, 1'b0);
    end else if (kind < 80) begin
      utf8_seq(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3, 1'b0);
    end else if (kind < 84) begin
      utf8_seq(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4, 1'b0);
    end else if (kind < 88) begin
      b = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                               : 8'($urandom_range(0, 2) == 0 ? 8'hC0 + $urandom_range(0, 1)
                                                              : $urandom_range(8'hF5, 8'hFF));
      send_byte(b, 1'b0);
    end else if (kind < 93) begin
      utf8_seq(cp, len, $urandom_range(1, len - 1), 1'b0);
      b = 8'($urandom);
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      send_byte(b, $urandom_range(0, 7) == 0);
    end else if (kind < 97) begin
      utf8_seq(cp, len, $urandom_range(1, len - 1), 1'b1);
    end else begin
      send_byte(any_byte(), 1'($urandom));
    end
  endtask

  task automatic cp8_item();
    logic [7:0] b;
    int         k;
    b = any_byte();
    if (b[7] && !written[b[6:0]]) begin
      // Only loaded entries may be looked up.
      k = $urandom_range(0, TABLE_DEPTH - 1);
      while (!written[k]) k = (k + 1) % TABLE_DEPTH;
      b = {1'b1, 7'(k)};
    end
    send_byte(b, $urandom_range(0, 19) == 0);
  endtask

  initial begin : receiver
    int stall;
    int calm;
    bit held;
    calm = 0;
    held = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (!held && sent_count >= HOLD_AT) begin
        // One long hold-off so that the block backs up and stalls its input.
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (calm > 0) calm--;
        else if ($urandom_range(0, 15) == 0) calm = $urandom_range(30, 150);
        stall = (calm > 0) ? 0 : random_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int         goal;
    int         phase;
    int         phase_end;
    logic [2:0] m;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // UTF-8 after reset: ASCII ends, a 2-byte and the largest 4-byte form,
    // stray continuation, bad lead, surrogate, interrupted sequence,
    // table write in mid-sequence, and a sequence cut short by the last byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    utf8_seq(21'h10FFFF, 4, 4, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    utf8_seq(21'hD800, 3, 3, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    load_entry(7'd0, 16'h0000);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    load_entry(7'd127, 16'hFFFF);

    set_mode(MODE_CP8);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);

    goal  = sent_count + RAND_ITEMS;
    phase = 0;
    while (sent_count < goal) begin
      m = (phase < 6) ? 3'(phase) : 3'($urandom_range(0, 5));
      phase++;
      calm_sender = ($urandom_range(0, 3) == 0);
      set_mode(m);
      phase_end = sent_count + $urandom_range(40, 160);
      while (sent_count < phase_end) begin
        if ($urandom_range(0, 19) == 0)
          load_entry(7'($urandom), ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
        else if (m == MODE_CP8)
          cp8_item();
        else if (m == MODE_UTF8)
          utf8_item();
        else
          send_byte(any_byte(), $urandom_range(0, 24) == 0);
      end
    end
    calm_sender = 1'b0;

    settle();
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin : watchdog
    #(4_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

/* text_byte_stream_decoder.f */
src/tbsd_pkg.sv
src/tbsd_front.sv
src/tbsd_queue.sv
src/tbsd_back.sv
src/text_byte_stream_decoder.sv
bench/decode_checker.sv
bench/tb_text_byte_stream_decoder.sv
